@@ hw/rtl/deq_pkg.sv @@
// Shared types and constants for the double-ended queue.
package deq_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned DATA_W           = 32;
  localparam int unsigned ACTION_W         = 2;
  localparam int unsigned OCC_W            = 5;
  localparam int unsigned DEFAULT_CAPACITY = 16;

  // Operation codes carried on the action field.
  typedef enum logic [ACTION_W-1:0] {
    ACT_INS_FRONT = 2'd0,
    ACT_INS_REAR  = 2'd1,
    ACT_DEL_FRONT = 2'd2,
    ACT_DEL_REAR  = 2'd3
  } deq_action_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // an input transfer happens this cycle
    logic capture;  // memory read data is valid this cycle
  } deq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_read;  // the accepted operation must refetch an end entry
  } deq_status_t;

endpackage

@@ hw/rtl/deq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module deq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/deq_ctrl.sv @@
// Controller state machine that sequences one queue operation at a time.
module deq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  deq_pkg::deq_status_t status_i,
  output deq_pkg::deq_cmd_t    cmd_o
);
  import deq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_OUT
  } state_e;

  state_e state_q;
  logic   in_stall_q;
  logic   out_valid_q;
  logic   accept;

  // An input transfer is taken only while idle.
  assign accept = (state_q == ST_IDLE) && in_valid_i && !in_stall_q;

  // State and registered handshake outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_stall_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            in_stall_q <= 1'b1;
            if (status_i.need_read) begin
              state_q <= ST_READ;
            end else begin
              state_q     <= ST_OUT;
              out_valid_q <= 1'b1;
            end
          end
        end
        ST_READ: begin
          state_q     <= ST_OUT;
          out_valid_q <= 1'b1;
        end
        ST_OUT: begin
          if (!out_stall_i) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b0;
            in_stall_q  <= 1'b0;
          end
        end
        default: begin
          state_q     <= ST_IDLE;
          out_valid_q <= 1'b0;
          in_stall_q  <= 1'b0;
        end
      endcase
    end
  end

  assign cmd_o.accept  = accept;
  assign cmd_o.capture = (state_q == ST_READ);
  assign in_stall_o    = in_stall_q;
  assign out_valid_o   = out_valid_q;

endmodule

@@ hw/rtl/deq_datapath.sv @@
// Datapath: ring storage, head and count registers, cached end values.
module deq_datapath #(
  parameter int unsigned CAPACITY = deq_pkg::DEFAULT_CAPACITY
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  deq_pkg::deq_cmd_t                   cmd_i,
  output deq_pkg::deq_status_t                status_o,
  input  logic [deq_pkg::ACTION_W-1:0]        action_i,
  input  logic signed [deq_pkg::DATA_W-1:0]   value_i,
  output logic signed [deq_pkg::DATA_W-1:0]   removed_value_o,
  output logic                                status_bit_o,
  output logic signed [deq_pkg::DATA_W-1:0]   front_value_o,
  output logic signed [deq_pkg::DATA_W-1:0]   rear_value_o,
  output logic [deq_pkg::OCC_W-1:0]           occupancy_o,
  output logic                                is_empty_o,
  output logic                                is_full_o
);
  import deq_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned SUM_W = IDX_W + 1;

  // Ring slot of base plus offset, both below the capacity.
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= SUM_W'(CAPACITY)) begin
      sum = sum - SUM_W'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  logic [IDX_W-1:0]         head_q, head_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic signed [DATA_W-1:0] front_q, front_d;
  logic signed [DATA_W-1:0] rear_q, rear_d;
  logic signed [DATA_W-1:0] removed_q, removed_d;
  logic                     reject_q, reject_d;
  logic                     rd_front_q, rd_front_d;

  logic                     full, empty;
  logic [IDX_W-1:0]         head_dec, head_inc;
  logic                     we;
  logic [IDX_W-1:0]         waddr;
  logic                     need_read;
  logic [IDX_W-1:0]         raddr;
  logic [DATA_W-1:0]        rdata;

  assign full     = (count_q == CNT_W'(CAPACITY));
  assign empty    = (count_q == '0);
  assign head_dec = (head_q == '0) ? IDX_W'(CAPACITY - 1) : head_q - IDX_W'(1);
  assign head_inc = (head_q == IDX_W'(CAPACITY - 1)) ? '0 : head_q + IDX_W'(1);

  // Operation decode: next head, count, cached ends, memory write and refetch.
  always_comb begin
    head_d     = head_q;
    count_d    = count_q;
    front_d    = front_q;
    rear_d     = rear_q;
    removed_d  = '0;
    reject_d   = 1'b0;
    rd_front_d = rd_front_q;
    we         = 1'b0;
    waddr      = head_dec;
    need_read  = 1'b0;
    raddr      = head_inc;
    case (deq_action_e'(action_i))
      ACT_INS_FRONT: begin
        if (full) begin
          reject_d = 1'b1;
        end else begin
          head_d  = head_dec;
          count_d = count_q + CNT_W'(1);
          we      = 1'b1;
          waddr   = head_dec;
          front_d = value_i;
          if (empty) begin
            rear_d = value_i;
          end
        end
      end
      ACT_INS_REAR: begin
        if (full) begin
          reject_d = 1'b1;
        end else begin
          count_d = count_q + CNT_W'(1);
          we      = 1'b1;
          waddr   = wrap_add(head_q, IDX_W'(count_q));
          rear_d  = value_i;
          if (empty) begin
            front_d = value_i;
          end
        end
      end
      ACT_DEL_FRONT: begin
        if (empty) begin
          reject_d = 1'b1;
        end else begin
          removed_d  = front_q;
          head_d     = head_inc;
          count_d    = count_q - CNT_W'(1);
          need_read  = (count_q > CNT_W'(1));
          raddr      = head_inc;
          rd_front_d = 1'b1;
        end
      end
      ACT_DEL_REAR: begin
        if (empty) begin
          reject_d = 1'b1;
        end else begin
          removed_d  = rear_q;
          count_d    = count_q - CNT_W'(1);
          need_read  = (count_q > CNT_W'(1));
          raddr      = wrap_add(head_q, IDX_W'(count_q - CNT_W'(2)));
          rd_front_d = 1'b0;
        end
      end
      default: begin
        reject_d = 1'b1;
      end
    endcase
  end

  assign status_o.need_read = need_read;

  // Entry storage.
  deq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept && we),
    .waddr_i (waddr),
    .wdata_i (value_i),
    .re_i    (cmd_i.accept && need_read),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Ring pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.accept) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // Result and cached end values; a refetched end is loaded from the registered read data on capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      front_q    <= front_d;
      rear_q     <= rear_d;
      removed_q  <= removed_d;
      reject_q   <= reject_d;
      rd_front_q <= rd_front_d;
    end else if (cmd_i.capture) begin
      if (rd_front_q) begin
        front_q <= rdata;
      end else begin
        rear_q <= rdata;
      end
    end
  end

  // Result fields; end values read as zero when the queue is empty.
  assign removed_value_o = removed_q;
  assign status_bit_o    = reject_q;
  assign front_value_o   = empty ? '0 : front_q;
  assign rear_value_o    = empty ? '0 : rear_q;
  assign occupancy_o     = OCC_W'(count_q);
  assign is_empty_o      = empty;
  assign is_full_o       = full;

endmodule

@@ hw/rtl/double_ended_queue.sv @@
// Top level of the bounded double-ended queue of signed 32-bit values.
// Inserts, rejected operations and deletes that empty the queue go straight to the output state,
// while deletes that leave entries first pass through a read state for the memory read of the new end.
// The queue takes one operation at a time: the input stays stalled until the result is taken.
// The ring memory has a single registered read port, which is why such deletes need the read state.
// Reset clears head and count, so the queue starts empty; the memory itself is not cleared.
module double_ended_queue #(
  parameter int unsigned CAPACITY = deq_pkg::DEFAULT_CAPACITY
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [deq_pkg::ACTION_W-1:0]        action_i,
  input  logic signed [deq_pkg::DATA_W-1:0]   value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [deq_pkg::DATA_W-1:0]   removed_value_o,
  output logic                                status_o,
  output logic signed [deq_pkg::DATA_W-1:0]   front_value_o,
  output logic signed [deq_pkg::DATA_W-1:0]   rear_value_o,
  output logic [deq_pkg::OCC_W-1:0]           occupancy_o,
  output logic                                is_empty_o,
  output logic                                is_full_o
);
  import deq_pkg::*;

  deq_cmd_t    cmd;
  deq_status_t dp_status;

  // Sequencing of transfers and memory reads.
  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  // Storage and result computation.
  deq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (dp_status),
    .action_i        (action_i),
    .value_i         (value_i),
    .removed_value_o (removed_value_o),
    .status_bit_o    (status_o),
    .front_value_o   (front_value_o),
    .rear_value_o    (rear_value_o),
    .occupancy_o     (occupancy_o),
    .is_empty_o      (is_empty_o),
    .is_full_o       (is_full_o)
  );

endmodule
